>>> hdl/imh_pkg.sv
`timescale 1ns / 1ps
package imh_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int KEY_BITS = 48;
	localparam int SLOT_BITS = $clog2(HEAP_DEPTH);
	localparam int SIZE_BITS = SLOT_BITS + 1;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_UPDATE = 2'd2;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(HEAP_DEPTH);

	// Controller commands to the datapath.
	typedef struct packed {
		logic start;     // latch the request and size
		logic rd_cur;    // read entry at cur slot
		logic lat_cur;   // capture cur entry as the moving item
		logic rd_par;    // read parent of cur
		logic rd_kids;   // read both children of cur
		logic move_par;  // write parent entry to cur, cur <= parent
		logic move_kid;  // write smaller child to cur, cur <= child
		logic put;       // write moving item at cur
		logic load_wr;   // write load entry
		logic upd_map;   // read element_to_slot of id
		logic set_slot;  // cur <= map read data
		logic build_nx;  // cur <= next build slot
		logic rd_root;   // read slot 0
		logic finish;    // capture result
	} imh_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic id_ok;       // id below size
		logic has_par;     // cur above zero
		logic par_less;    // moving key below parent key
		logic has_kid;     // left child below size
		logic kid_less;    // smaller child key below moving key
		logic build_any;   // size above one
		logic build_last;  // current build slot is zero
	} imh_sts_t;

endpackage

>>> hdl/imh_ctrl.sv
`timescale 1ns / 1ps
module imh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	output logic              out_valid,
	input  logic              out_ready,
	input  imh_pkg::imh_sts_t sts,
	output imh_pkg::imh_cmd_t cmd
);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_LOAD  = 13'b0000000000010,
		ST_MAP   = 13'b0000000000100,
		ST_SLOT  = 13'b0000000001000,
		ST_CUR   = 13'b0000000010000,
		ST_PAR   = 13'b0000000100000,
		ST_PCMP  = 13'b0000001000000,
		ST_KIDS  = 13'b0000010000000,
		ST_KCMP  = 13'b0000100000000,
		ST_ROOT  = 13'b0001000000000,
		ST_DONE  = 13'b0010000000000,
		ST_BNEXT = 13'b0100000000000,
		ST_DOWN  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] req_q;
	logic up_q;   // update sift begins by checking the parent
	logic out_valid_q;

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= imh_pkg::REQ_LOAD;
			up_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) req_q <= req_type;
			if (state_q == ST_SLOT) up_q <= 1'b1;
			else if (state_q == ST_PCMP) up_q <= 1'b0;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.start = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (req_q == imh_pkg::REQ_LOAD) begin
					cmd.load_wr = sts.id_ok;
					state_d = ST_DONE;
				end else if (req_q == imh_pkg::REQ_UPDATE) begin
					if (sts.id_ok) begin
						cmd.upd_map = 1'b1;
						state_d = ST_MAP;
					end else begin
						state_d = ST_ROOT;
					end
				end else if (req_q == imh_pkg::REQ_BUILD) begin
					if (sts.build_any) begin
						cmd.build_nx = 1'b1;
						state_d = ST_BNEXT;
					end else begin
						state_d = ST_ROOT;
					end
				end else begin
					state_d = ST_ROOT;
				end
			end
			ST_MAP: state_d = ST_SLOT;
			ST_SLOT: begin
				cmd.set_slot = 1'b1;
				state_d = ST_CUR;
			end
			ST_BNEXT: begin
				cmd.rd_cur = 1'b1;
				state_d = ST_PAR;
			end
			ST_CUR: begin
				cmd.rd_cur = 1'b1;
				state_d = ST_PAR;
			end
			ST_PAR: begin
				// Cur entry is on the read port; an update substitutes its new key.
				cmd.lat_cur = 1'b1;
				if (up_q) begin
					cmd.rd_par = 1'b1;
					state_d = ST_PCMP;
				end else begin
					cmd.rd_kids = 1'b1;
					state_d = ST_KCMP;
				end
			end
			ST_PCMP: begin
				if (sts.has_par && sts.par_less) begin
					cmd.move_par = 1'b1;
					state_d = ST_KIDS;
				end else if (up_q) begin
					// The first check found no smaller parent, so the update sifts down.
					cmd.rd_kids = 1'b1;
					state_d = ST_KCMP;
				end else begin
					cmd.put = 1'b1;
					state_d = ST_ROOT;
				end
			end
			ST_KIDS: begin
				// Sift up continues with the next parent, or places the item at the root.
				cmd.rd_par = 1'b1;
				state_d = ST_ROOT;
				if (sts.has_par) state_d = ST_PCMP;
				else begin
					cmd.put = 1'b1;
					cmd.rd_par = 1'b0;
				end
			end
			ST_DOWN: begin
				// Sift down continues with the children of the new slot.
				cmd.rd_kids = 1'b1;
				state_d = ST_KCMP;
			end
			ST_KCMP: begin
				if (sts.has_kid && sts.kid_less) begin
					cmd.move_kid = 1'b1;
					state_d = ST_DOWN;
				end else begin
					cmd.put = 1'b1;
					if (req_q == imh_pkg::REQ_BUILD && !sts.build_last) begin
						state_d = ST_BNEXT;
						cmd.build_nx = 1'b1;
					end else begin
						state_d = ST_ROOT;
					end
				end
			end
			ST_ROOT: begin
				cmd.rd_root = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("result lost");
endmodule

>>> hdl/imh_datapath.sv
`timescale 1ns / 1ps
module imh_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  imh_pkg::imh_cmd_t                    cmd,
	output imh_pkg::imh_sts_t                    sts,
	input  logic [imh_pkg::SIZE_BITS-1:0]        heap_size,
	input  logic [1:0]                           req_type,
	input  logic [imh_pkg::SLOT_BITS-1:0]        element_id,
	input  logic [imh_pkg::KEY_BITS-1:0]         new_key,
	output logic [imh_pkg::SLOT_BITS-1:0]        min_element,
	output logic [imh_pkg::KEY_BITS-1:0]         min_key,
	output logic                                 status
);
	localparam int SB = imh_pkg::SLOT_BITS;
	localparam int KB = imh_pkg::KEY_BITS;
	localparam int ZB = imh_pkg::SIZE_BITS;

	// Two copies of key and element stores give two read ports.
	logic [KB-1:0] key_a [imh_pkg::HEAP_DEPTH];
	logic [KB-1:0] key_b [imh_pkg::HEAP_DEPTH];
	logic [SB-1:0] elm_a [imh_pkg::HEAP_DEPTH];
	logic [SB-1:0] elm_b [imh_pkg::HEAP_DEPTH];
	logic [SB-1:0] e2s [imh_pkg::HEAP_DEPTH];

	logic [1:0] req_q;
	logic [SB-1:0] id_q;
	logic [KB-1:0] nkey_q;
	logic [ZB-1:0] n_q;
	logic [SB-1:0] cur_q;
	logic [ZB-1:0] bld_q;     // current build slot plus one
	logic [KB-1:0] mkey_q;
	logic [SB-1:0] melm_q;
	logic [KB-1:0] ka_q, kb_q;
	logic [SB-1:0] ea_q, eb_q, map_q;
	logic [SB-1:0] min_e_q;
	logic [KB-1:0] min_k_q;
	logic status_q;

	logic wr_en;
	logic [SB-1:0] wr_addr, wr_elm;
	logic [KB-1:0] wr_key;
	logic [SB-1:0] ra_addr, rb_addr, par;
	logic [ZB:0] lc, rc;
	logic rc_ok, pick_b;
	logic [KB-1:0] cur_key;

	assign par = SB'((cur_q - 1'b1) >> 1);
	assign lc = {1'b0, cur_q, 1'b1};
	assign rc = lc + 1'b1;
	assign rc_ok = rc < {1'b0, n_q};
	assign pick_b = rc_ok && (kb_q < ka_q);

	// Status for the controller.
	always_comb begin
		sts.id_ok = {1'b0, id_q} < n_q;
		sts.has_par = cur_q != '0;
		sts.par_less = mkey_q < ka_q;
		sts.has_kid = lc < {1'b0, n_q};
		sts.kid_less = (pick_b ? kb_q : ka_q) < mkey_q;
		sts.build_any = n_q > ZB'(1);
		sts.build_last = bld_q == ZB'(1);
	end

	// Read addresses.
	always_comb begin
		ra_addr = cur_q;
		rb_addr = SB'(rc);
		if (cmd.rd_par) ra_addr = par;
		else if (cmd.rd_kids) ra_addr = SB'(lc);
		else if (cmd.rd_root) ra_addr = '0;
	end

	// At most one write per cycle into the key, element and slot-map stores.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_key = mkey_q;
		wr_elm = melm_q;
		if (cmd.load_wr) begin
			wr_en = 1'b1;
			wr_addr = id_q;
			wr_key = nkey_q;
			wr_elm = id_q;
		end else if (cmd.move_par) begin
			wr_en = 1'b1;
			wr_key = ka_q;
			wr_elm = ea_q;
		end else if (cmd.move_kid) begin
			wr_en = 1'b1;
			wr_key = pick_b ? kb_q : ka_q;
			wr_elm = pick_b ? eb_q : ea_q;
		end else if (cmd.put) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_a[wr_addr] <= wr_key;
			key_b[wr_addr] <= wr_key;
			elm_a[wr_addr] <= wr_elm;
			elm_b[wr_addr] <= wr_elm;
			e2s[wr_elm] <= wr_addr;
		end
		ka_q <= key_a[ra_addr];
		ea_q <= elm_a[ra_addr];
		kb_q <= key_b[rb_addr];
		eb_q <= elm_b[rb_addr];
		map_q <= e2s[id_q];
	end

	// An update replaces the key of the entry it moves.
	assign cur_key = (req_q == imh_pkg::REQ_UPDATE) ? nkey_q : ka_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 1'b0;
		end else if (cmd.finish) begin
			status_q <= (req_q == imh_pkg::REQ_LOAD || req_q == imh_pkg::REQ_UPDATE)
				&& !sts.id_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req_type;
			id_q <= element_id;
			nkey_q <= new_key;
			n_q <= (heap_size > ZB'(imh_pkg::HEAP_DEPTH)) ? ZB'(imh_pkg::HEAP_DEPTH)
				: heap_size;
		end
		if (cmd.start) bld_q <= '0;
		else if (cmd.build_nx) begin
			if (bld_q == '0) begin
				bld_q <= n_q >> 1;
				cur_q <= SB'((n_q >> 1) - 1'b1);
			end else begin
				bld_q <= bld_q - 1'b1;
				cur_q <= SB'(bld_q - ZB'(2));
			end
		end else if (cmd.set_slot) cur_q <= map_q;
		else if (cmd.move_par) cur_q <= par;
		else if (cmd.move_kid) cur_q <= pick_b ? SB'(rc) : SB'(lc);
		if (cmd.lat_cur) begin
			mkey_q <= cur_key;
			melm_q <= ea_q;
		end
		if (cmd.finish) begin
			min_e_q <= (req_q == imh_pkg::REQ_LOAD) ? '0 : ea_q;
			min_k_q <= (req_q == imh_pkg::REQ_LOAD) ? '0 : ka_q;
		end
	end

	assign min_element = min_e_q;
	assign min_key = min_k_q;
	assign status = status_q;

	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.move_par && cmd.move_kid)) else $error("two moves");
	a_kid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move_kid |-> sts.has_kid) else $error("child beyond size");
	a_par_exists: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move_par |-> sts.has_par) else $error("parent of root");
endmodule

>>> hdl/indexed_min_heap_update_unit.sv
`timescale 1ns / 1ps
// Channel | Signals                                   | Direction
// in      | in_valid/in_ready, req_type, element_id,  | into block
//         | new_key                                   |
// out     | out_valid/out_ready, min_element,         | out of block
//         | min_key, status                           |
// cfg     | APB psel/penable/pwrite/paddr/pwdata      | register heap_size
// One item at a time; a load goes straight to its result, while a rejected update, an unused
// type or a build of at most one slot first reads the root. An update sifts one heap level
// at a time, and a build sifts each inner slot in turn, from the last down to slot zero.
// The single-write key store and its per-level read and compare set the pace.
// Reset clears control and sets heap_size to 1024; stores hold garbage until loaded.
// A held result blocks the next item, which is accepted in the cycle after it is taken.
module indexed_min_heap_update_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [imh_pkg::SLOT_BITS-1:0]       element_id,
	input  logic [imh_pkg::KEY_BITS-1:0]        new_key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [imh_pkg::SLOT_BITS-1:0]       min_element,
	output logic [imh_pkg::KEY_BITS-1:0]        min_key,
	output logic                                status,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [1:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	imh_pkg::imh_cmd_t cmd;
	imh_pkg::imh_sts_t sts;
	logic [imh_pkg::SIZE_BITS-1:0] size_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? 32'(size_q) : 32'd0;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= imh_pkg::SIZE_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0)
			size_q <= pwdata[imh_pkg::SIZE_BITS-1:0];
	end

	imh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	imh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .heap_size(size_q),
		.req_type(req_type), .element_id(element_id), .new_key(new_key),
		.min_element(min_element), .min_key(min_key), .status(status)
	);
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic [1:0] HEAP_SIZE_ADDR = 2'd0;
	localparam int SB = imh_pkg::SLOT_BITS;
	localparam int KB = imh_pkg::KEY_BITS;
	localparam int ZB = imh_pkg::SIZE_BITS;
	localparam int DEPTH = imh_pkg::HEAP_DEPTH;

	typedef struct {
		logic [1:0]    req;
		logic [SB-1:0] id;
		logic [KB-1:0] key;
	} heap_req_t;

	typedef struct {
		logic [SB-1:0] elem;
		logic [KB-1:0] key;
		logic          rejected;
	} root_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [SB-1:0] element_id = '0;
	logic [KB-1:0] new_key = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SB-1:0] min_element;
	logic [KB-1:0] min_key;
	logic status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	indexed_min_heap_update_unit dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the heap and its two maps.
	logic [KB-1:0] shadow_keys [DEPTH];
	logic [SB-1:0] shadow_slot_elem [DEPTH];
	logic [SB-1:0] shadow_elem_slot [DEPTH];
	logic [ZB-1:0] shadow_size = imh_pkg::SIZE_RESET;

	heap_req_t pending_reqs[$];
	root_report_t root_reports[$];
	int mismatches = 0;
	bit quiet = 1'b0;

	function automatic int live_size();
		return (shadow_size > DEPTH) ? DEPTH : int'(shadow_size);
	endfunction

	function automatic void heap_place(int slot, logic [KB-1:0] key,
			logic [SB-1:0] elem);
		shadow_keys[slot] = key;
		shadow_slot_elem[slot] = elem;
		shadow_elem_slot[elem] = slot[SB-1:0];
	endfunction

	function automatic void heap_sink(int slot, int n);
		logic [KB-1:0] key;
		logic [SB-1:0] elem;
		int c;
		key = shadow_keys[slot];
		elem = shadow_slot_elem[slot];
		while (2 * slot + 1 < n) begin
			c = 2 * slot + 1;
			if (c + 1 < n && shadow_keys[c + 1] < shadow_keys[c])
				c++;
			if (!(shadow_keys[c] < key))
				break;
			heap_place(slot, shadow_keys[c], shadow_slot_elem[c]);
			slot = c;
		end
		heap_place(slot, key, elem);
	endfunction

	function automatic void heap_raise(int slot);
		logic [KB-1:0] key;
		logic [SB-1:0] elem;
		int p;
		key = shadow_keys[slot];
		elem = shadow_slot_elem[slot];
		while (slot > 0) begin
			p = (slot - 1) / 2;
			if (!(key < shadow_keys[p]))
				break;
			heap_place(slot, shadow_keys[p], shadow_slot_elem[p]);
			slot = p;
		end
		heap_place(slot, key, elem);
	endfunction

	// Apply one request to the shadow heap and return the root it reports.
	function automatic root_report_t heap_apply(heap_req_t r);
		root_report_t rep;
		int n;
		int slot;
		n = live_size();
		rep.rejected = 1'b0;
		case (r.req)
			imh_pkg::REQ_LOAD: begin
				if (int'(r.id) < n)
					heap_place(int'(r.id), r.key, r.id);
				else
					rep.rejected = 1'b1;
			end
			imh_pkg::REQ_BUILD: begin
				for (int i = n / 2; i > 0; i--)
					heap_sink(i - 1, n);
			end
			imh_pkg::REQ_UPDATE: begin
				if (int'(r.id) < n) begin
					slot = int'(shadow_elem_slot[r.id]);
					shadow_keys[slot] = r.key;
					if (slot > 0 && r.key < shadow_keys[(slot - 1) / 2])
						heap_raise(slot);
					else
						heap_sink(slot, n);
				end else begin
					rep.rejected = 1'b1;
				end
			end
			default: ;
		endcase
		if (r.req == imh_pkg::REQ_LOAD) begin
			rep.elem = '0;
			rep.key = '0;
		end else begin
			rep.elem = shadow_slot_elem[0];
			rep.key = shadow_keys[0];
		end
		return rep;
	endfunction

	// Driver: feeds pending items with random idle bursts.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		heap_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				r.req = req_type;
				r.id = element_id;
				r.key = new_key;
				root_reports.push_back(heap_apply(r));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= r.req;
					element_id <= r.id;
					new_key <= r.key;
					if (!quiet && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random stalls on the result side and field-wise compare.
	int take_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		root_report_t exp_rep;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (root_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: elem %0d key %h status %0d",
							min_element, min_key, status);
				end else begin
					exp_rep = root_reports.pop_front();
					if (min_element !== exp_rep.elem || min_key !== exp_rep.key ||
							status !== exp_rep.rejected) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected elem %0d key %h status %0d, ",
								exp_rep.elem, exp_rep.key, exp_rep.rejected,
								"got elem %0d key %h status %0d",
								min_element, min_key, status);
					end
				end
			end
			if (take_gap > 0) begin
				take_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					take_gap = $urandom_range(1, 6);
			end
		end
	end

	// Watchdog on cycles with no item moving on either channel and no register access.
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [KB-1:0] rand_key();
		logic [KB-1:0] k;
		k = KB'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: k = KB'($urandom_range(0, 15));
			1: k = $urandom_range(0, 1) ? '1 : '0;
			default: ;
		endcase
		return k;
	endfunction

	task automatic push_req(logic [1:0] req, int id, logic [KB-1:0] key);
		heap_req_t r;
		r.req = req;
		r.id = id[SB-1:0];
		r.key = key;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || root_reports.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_heap_size(int value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= HEAP_SIZE_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_size = value[ZB-1:0];
	endtask

	// One phase: set the size, optionally fill and build, then mixed requests.
	task automatic run_phase(int size_val, bit fill, int n_ops);
		int n;
		int pick;
		n = (size_val > DEPTH) ? DEPTH : size_val;
		write_heap_size(size_val);
		if (fill) begin
			for (int i = 0; i < n; i++)
				push_req(imh_pkg::REQ_LOAD, i, rand_key());
			push_req(imh_pkg::REQ_BUILD, $urandom_range(0, 1023), rand_key());
		end
		for (int k = 0; k < n_ops; k++) begin
			pick = $urandom_range(0, 99);
			if (n == 0 || (pick >= 70 && pick < 78 && n < DEPTH))
				push_req($urandom_range(0, 1) ? imh_pkg::REQ_UPDATE : imh_pkg::REQ_LOAD,
					$urandom_range(n, 1023), rand_key());
			else if (pick < 70)
				push_req(imh_pkg::REQ_UPDATE, $urandom_range(0, n - 1), rand_key());
			else if (pick < 86)
				push_req(imh_pkg::REQ_LOAD, $urandom_range(0, n - 1), rand_key());
			else if (pick < 93)
				push_req(imh_pkg::REQ_BUILD, $urandom_range(0, 1023), rand_key());
			else
				push_req(REQ_SPARE, $urandom_range(0, 1023), rand_key());
		end
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small heap, extremes, both sift directions, rejects.
		write_heap_size(3);
		push_req(imh_pkg::REQ_LOAD, 0, '1);
		push_req(imh_pkg::REQ_LOAD, 1, '0);
		push_req(imh_pkg::REQ_LOAD, 2, 48'h8000_0000_0001);
		push_req(imh_pkg::REQ_LOAD, 3, 48'h1234);
		push_req(imh_pkg::REQ_LOAD, 1023, '1);
		push_req(imh_pkg::REQ_BUILD, 1023, '1);
		push_req(REQ_SPARE, 1023, '1);
		push_req(imh_pkg::REQ_UPDATE, 0, '0);
		push_req(imh_pkg::REQ_UPDATE, 1, '1);
		push_req(imh_pkg::REQ_UPDATE, 2, '1);
		push_req(imh_pkg::REQ_UPDATE, 2, 48'h1);
		push_req(imh_pkg::REQ_UPDATE, 5, '0);
		push_req(imh_pkg::REQ_UPDATE, 1023, '0);
		push_req(imh_pkg::REQ_LOAD, 1, 48'h5);
		push_req(imh_pkg::REQ_UPDATE, 0, 48'h5);
		push_req(imh_pkg::REQ_BUILD, 0, '0);
		wait_drained();
		write_heap_size(1);
		push_req(imh_pkg::REQ_LOAD, 0, 48'h7);
		push_req(imh_pkg::REQ_BUILD, 0, '0);
		push_req(imh_pkg::REQ_UPDATE, 0, '1);
		push_req(imh_pkg::REQ_UPDATE, 1, '0);
		push_req(imh_pkg::REQ_LOAD, 512, '0);
		wait_drained();

		// Shrinking below loaded slots leaves stale entries that still sift.
		run_phase(2, 1'b1, 5);
		run_phase(1024, 1'b1, 40);
		run_phase(2047, 1'b0, 30);
		run_phase(0, 1'b0, 10);
		run_phase(100, 1'b0, 20);
		run_phase(5, 1'b1, 20);
		run_phase(37, 1'b1, 30);
		run_phase(16, 1'b0, 20);
		quiet = 1'b1;
		run_phase(64, 1'b1, 30);

		if (mismatches == 0 && root_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
